FILE: sv/congestion_window_sender_macros.svh
// ----------------------------------------------------------------------------
// Congestion window sender assertion macros
// Shared concurrent assertion forms for the congestion window sender modules.
// ----------------------------------------------------------------------------
`ifndef CONGESTION_WINDOW_SENDER_MACROS_SVH
`define CONGESTION_WINDOW_SENDER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cws: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cws: assertion failed");

`else

`define CWS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/cws_pkg.sv
// ----------------------------------------------------------------------------
// Congestion window sender package
// Types, codes and default constants shared by the sender modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cws_pkg;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SEQ_BITS    = 16;
    localparam int WIN_W           = 7;
    localparam int FIELD_SEQ_W     = 16;
    localparam int CFG_DATA_W      = 16;
    localparam logic [15:0] LAST_SEG_RST    = 16'd1;
    localparam logic [6:0]  INIT_THRESH_RST = 7'd16;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_ACK     = 2'd1,
        FUNC_TIMEOUT = 2'd2,
        FUNC_FIN_ACK = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_NEW    = 2'd0,
        KIND_RESENT = 2'd1,
        KIND_FIN    = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        CFG_LAST_SEGMENT = 1'b0,
        CFG_INIT_THRESH  = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_BURST = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] ack_number;
        logic [15:0] ack_seq;
    } t_in_item;

    typedef struct packed {
        logic [15:0] seq;
        logic [1:0]  kind;
        logic [6:0]  window;
        logic        last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic evt;
        logic send;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic evt_emits;
        logic evt_burst;
        logic burst_last;
    } t_sts;

endpackage

FILE: sv/cws_ctrl.sv
// ----------------------------------------------------------------------------
// Congestion window sender controller
// Handshake control, output valid flag and the event/burst state machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "congestion_window_sender_macros.svh"

module cws_ctrl
    import cws_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = !out_free;
                if (i_in_valid && out_free) begin
                    o_cmd.evt   = 1'b1;
                    n_out_valid = i_sts.evt_emits;
                    if (i_sts.evt_burst) begin
                        n_state = ST_BURST;
                    end
                end
            end
            ST_BURST: begin
                if (out_free) begin
                    o_cmd.send  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_sts.burst_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // No new event is taken while a burst is being issued.
    `CWS_ASSERT_NOW(a_no_accept_in_burst, i_clk, i_rst_n, r_state == ST_BURST, o_in_stall)
    // An event and a burst send never happen in the same cycle.
    `CWS_ASSERT_NOW(a_cmd_exclusive, i_clk, i_rst_n, o_cmd.evt, !o_cmd.send)
    // Every burst send leaves a result in the output register.
    `CWS_ASSERT_NEXT(a_send_fills_out, i_clk, i_rst_n, o_cmd.send, r_out_valid)

endmodule

FILE: sv/cws_dp.sv
// ----------------------------------------------------------------------------
// Congestion window sender datapath
// Window, threshold and sequence state, the send unit and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "congestion_window_sender_macros.svh"

module cws_dp
    import cws_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int SEQ_BITS   = DEF_SEQ_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output t_out_item             o_out_data
);

    localparam int CMP_W = (SEQ_BITS > FIELD_SEQ_W) ? SEQ_BITS : FIELD_SEQ_W;
    localparam logic [7:0]       MAX_WIN8 = 8'(MAX_WINDOW);
    localparam logic [WIN_W-1:0] MAX_WIN  = WIN_W'(MAX_WINDOW);

    logic [15:0]         r_last_seg,   n_last_seg;
    logic [WIN_W-1:0]    r_cwnd,       n_cwnd;
    logic [WIN_W-1:0]    r_ssthresh,   n_ssthresh;
    logic [WIN_W-1:0]    r_aiw,        n_aiw;
    logic [WIN_W-1:0]    r_cnt,        n_cnt;
    logic [SEQ_BITS-1:0] r_next,       n_next;
    logic [SEQ_BITS-1:0] r_acked,      n_acked;
    logic [SEQ_BITS-1:0] r_high,       n_high;
    logic                r_fin,        n_fin;
    logic                r_closed,     n_closed;
    t_out_item           r_out,        n_out;

    logic [SEQ_BITS-1:0] ackn, ackq, send_base, send_seq, burst_seq;
    logic                send_new, send_fin, burst_fin;
    logic [7:0]          cwnd_grow;
    logic [WIN_W-1:0]    cwnd_sat, aiw_inc, half, thresh_to;

    assign ackn      = SEQ_BITS'(i_in_data.ack_number);
    assign ackq      = SEQ_BITS'(i_in_data.ack_seq);
    // One adder serves start, burst and timeout resend.
    assign send_base = (!i_cmd.send && i_in_data.func == FUNC_TIMEOUT) ? r_acked : r_next;
    assign send_seq  = send_base + SEQ_BITS'(1);
    assign send_new  = send_seq > r_high;
    assign send_fin  = CMP_W'(send_seq) >= CMP_W'(r_last_seg);
    // The next burst segment, used only for the end-of-burst status.
    assign burst_seq = r_next + SEQ_BITS'(1);
    assign burst_fin = CMP_W'(burst_seq) >= CMP_W'(r_last_seg);
    assign cwnd_grow = (r_cwnd < r_ssthresh) ? {r_cwnd, 1'b0} : ({1'b0, r_cwnd} + 8'd1);
    assign cwnd_sat  = (cwnd_grow > MAX_WIN8) ? MAX_WIN : cwnd_grow[WIN_W-1:0];
    assign aiw_inc   = (r_aiw == '1) ? r_aiw : r_aiw + WIN_W'(1);
    assign half      = r_cwnd >> 1;
    assign thresh_to = (half > WIN_W'(1)) ? half : WIN_W'(1);
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seg <= LAST_SEG_RST;
            r_cwnd     <= WIN_W'(1);
            r_ssthresh <= INIT_THRESH_RST;
            r_aiw      <= '0;
            r_cnt      <= '0;
            r_next     <= '0;
            r_acked    <= '0;
            r_high     <= '0;
            r_fin      <= 1'b0;
            r_closed   <= 1'b0;
        end else begin
            r_last_seg <= n_last_seg;
            r_cwnd     <= n_cwnd;
            r_ssthresh <= n_ssthresh;
            r_aiw      <= n_aiw;
            r_cnt      <= n_cnt;
            r_next     <= n_next;
            r_acked    <= n_acked;
            r_high     <= n_high;
            r_fin      <= n_fin;
            r_closed   <= n_closed;
        end
        r_out <= n_out;
    end

    // Event classification, valid whenever an event is offered.
    always_comb begin
        o_sts = '0;
        if (!r_closed) begin
            unique case (i_in_data.func)
                FUNC_START: o_sts.evt_emits = 1'b1;
                FUNC_ACK: begin
                    if (r_fin && r_next == ackn) begin
                        o_sts.evt_emits = 1'b1;
                    end else if (ackn == ackq && aiw_inc >= r_cwnd) begin
                        o_sts.evt_burst = !r_fin;
                    end
                end
                FUNC_TIMEOUT: o_sts.evt_emits = (r_next != r_acked);
                FUNC_FIN_ACK: o_sts.evt_emits = 1'b0;
                default:      o_sts.evt_emits = 1'b0;
            endcase
        end
        o_sts.burst_last = ((r_cnt + WIN_W'(1)) == r_cwnd) || burst_fin;
    end

    always_comb begin
        n_last_seg = r_last_seg;
        n_cwnd     = r_cwnd;
        n_ssthresh = r_ssthresh;
        n_aiw      = r_aiw;
        n_cnt      = r_cnt;
        n_next     = r_next;
        n_acked    = r_acked;
        n_high     = r_high;
        n_fin      = r_fin;
        n_closed   = r_closed;
        n_out      = r_out;

        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_LAST_SEGMENT: n_last_seg = i_cfg_data;
                CFG_INIT_THRESH:  n_ssthresh = i_cfg_data[WIN_W-1:0];
                default:          n_last_seg = r_last_seg;
            endcase
        end

        if (i_cmd.evt && !r_closed) begin
            unique case (i_in_data.func)
                FUNC_START: begin
                    n_next = send_seq;
                    if (send_new) n_high = send_seq;
                    if (send_fin) n_fin = 1'b1;
                    n_out.seq    = FIELD_SEQ_W'(send_seq);
                    n_out.kind   = send_new ? KIND_NEW : KIND_RESENT;
                    n_out.window = r_cwnd;
                    n_out.last   = 1'b1;
                end
                FUNC_ACK: begin
                    n_acked = ackn;
                    if (r_fin && r_next == ackn) begin
                        n_out.seq    = '0;
                        n_out.kind   = KIND_FIN;
                        n_out.window = r_cwnd;
                        n_out.last   = 1'b1;
                    end else if (ackn == ackq) begin
                        if (aiw_inc >= r_cwnd) begin
                            n_aiw  = '0;
                            n_cwnd = cwnd_sat;
                            n_cnt  = '0;
                        end else begin
                            n_aiw = aiw_inc;
                        end
                    end
                end
                FUNC_TIMEOUT: begin
                    n_ssthresh = thresh_to;
                    if (r_next != r_acked) begin
                        n_cwnd = WIN_W'(1);
                        n_aiw  = '0;
                        n_next = send_seq;
                        n_fin  = send_fin;
                        if (send_new) n_high = send_seq;
                        n_out.seq    = FIELD_SEQ_W'(send_seq);
                        n_out.kind   = KIND_RESENT;
                        n_out.window = WIN_W'(1);
                        n_out.last   = 1'b1;
                    end
                end
                FUNC_FIN_ACK: n_closed = 1'b1;
                default:      n_closed = r_closed;
            endcase
        end

        if (i_cmd.send) begin
            n_next = send_seq;
            n_cnt  = r_cnt + WIN_W'(1);
            if (send_new) n_high = send_seq;
            if (send_fin) n_fin = 1'b1;
            n_out.seq    = FIELD_SEQ_W'(send_seq);
            n_out.kind   = send_new ? KIND_NEW : KIND_RESENT;
            n_out.window = r_cwnd;
            n_out.last   = o_sts.burst_last;
        end
    end

    // The window always stays between one and its ceiling.
    `CWS_ASSERT_NOW(a_cwnd_range, i_clk, i_rst_n, 1'b1, r_cwnd != '0 && r_cwnd <= MAX_WIN)
    // A burst never sends more requests than the window allows.
    `CWS_ASSERT_NOW(a_burst_bound, i_clk, i_rst_n, i_cmd.send, r_cnt < r_cwnd)
    // A closed session stays closed.
    `CWS_ASSERT_NEXT(a_closed_sticky, i_clk, i_rst_n, r_closed, r_closed)

endmodule

FILE: sv/congestion_window_sender.sv
// ----------------------------------------------------------------------------
// Congestion window sender
// Sender-side congestion window control: slow start, congestion avoidance,
// timeout fallback and session close, issuing segment send requests.
// ----------------------------------------------------------------------------
// A start, timeout or fin-acknowledged event starts no burst; start and
// a timeout with data outstanding give one request, an ack that covers the
// last sent segment while finishing gives one fin request. An in-order ack
// that completes the window grows it and, unless finishing, then issues a
// burst of up to cwnd (at most MAX_WINDOW) requests, one per cycle while
// the output is not stalled; the single send adder produces the sequence
// number of each request. A new event is not taken until the burst has
// been fully issued. Results wait in an output register; the next event is
// taken in the same cycle that a waiting result transfers, and while that
// result is stalled the input is stalled as well.
// The last flag marks the final request caused by an event. After a
// fin-acknowledged event all further events are taken and dropped until
// reset. Configuration writes are registered; writing the initial
// threshold loads the slow-start threshold register itself.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module congestion_window_sender
    import cws_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int SEQ_BITS   = DEF_SEQ_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // The controller owns the handshakes and sequencing of a burst.
    cws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the window state and the result register.
    cws_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .SEQ_BITS   (SEQ_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule
